>>> design/dfs_pkg.sv
// Shared request codes, state encoding and field width for the depth-first search block.
package dfs_pkg;

	localparam int FIELD_W = 4;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ADD   = 7'b0000010,
		S_HEAD  = 7'b0000100,
		S_CHECK = 7'b0001000,
		S_EDGE  = 7'b0010000,
		S_POP   = 7'b0100000,
		S_DONE  = 7'b1000000
	} dfs_state_t;

endpackage

>>> design/dfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/graph_depth_first_search.sv
// Directed graph store with edge lists in a shared edge pool and an iterative depth-first search.
//
// Pulse start while busy is low to hand over an item. Clear and add-edge items give no
// results. A search item walks the graph with a small sequencer over three RAMs (list
// heads, edge pool, frame stack), all with registered reads: each edge examined passes
// through S_CHECK and S_EDGE, each vertex entered also through S_HEAD for its list head,
// and each frame popped through S_CHECK and S_POP, or S_DONE for the last. Busy stays high
// until the walk ends, so no new item is taken while a search runs. Visited vertices come
// out in preorder on visited_vertex, each for one cycle with result_valid high; the
// receiver cannot hold them off. The last one of a search carries last_of_search and
// appears in the first cycle in which busy is low again. Results stream out while the
// search runs, one vertex behind the walk, so the last flag is exact.
module graph_depth_first_search
	import dfs_pkg::*;
#(
	parameter int NUM_VERTICES = 16,
	parameter int NUM_EDGES    = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [FIELD_W-1:0] edge_from,
	input  logic [FIELD_W-1:0] edge_to,
	input  logic [FIELD_W-1:0] source_vertex,
	output logic               result_valid,
	output logic [FIELD_W-1:0] visited_vertex,
	output logic               last_of_search
);

	localparam int VW = $clog2(NUM_VERTICES);
	localparam int DW = $clog2(NUM_VERTICES + 1);
	localparam int EW = $clog2(NUM_EDGES + 1);
	localparam int AW = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
	localparam logic [EW-1:0] NULL_LINK = EW'(NUM_EDGES);
	localparam logic [DW-1:0] FULL_DEPTH = DW'(NUM_VERTICES);

	dfs_state_t state_q;
	logic [DW-1:0]           depth_q;
	logic [EW-1:0]           cur_q;
	logic [EW-1:0]           used_q;
	logic [VW-1:0]           pend_q;
	logic [VW-1:0]           add_from_q;
	logic [VW-1:0]           add_to_q;
	logic [NUM_VERTICES-1:0] seen_q;
	logic [NUM_VERTICES-1:0] head_vld_q;
	logic                    head_vld_s1;
	logic                    res_vld_q;
	logic                    res_last_q;
	logic [VW-1:0]           res_vtx_q;

	logic [VW-1:0]    from_v;
	logic [VW-1:0]    to_v;
	logic [VW-1:0]    src_v;
	logic             from_ok;
	logic             to_ok;
	logic             src_ok;
	logic [VW-1:0]    hd_raddr;
	logic [EW-1:0]    hd_rdata;
	logic [EW-1:0]    head_eff;
	logic [VW+EW-1:0] pool_rdata;
	logic [VW-1:0]    pool_dest;
	logic [EW-1:0]    pool_next;
	logic [EW-1:0]    st_rdata;
	logic [VW-1:0]    st_waddr;
	logic [VW-1:0]    st_raddr;
	logic             push_ok;

	assign from_v  = VW'(edge_from);
	assign to_v    = VW'(edge_to);
	assign src_v   = VW'(source_vertex);
	assign from_ok = 32'(edge_from) < NUM_VERTICES;
	assign to_ok   = 32'(edge_to) < NUM_VERTICES;
	assign src_ok  = 32'(source_vertex) < NUM_VERTICES;

	assign busy = (state_q != S_IDLE);

	assign result_valid   = res_vld_q;
	assign last_of_search = res_last_q;
	assign visited_vertex = FIELD_W'(res_vtx_q);

	// A list head that has not been written since the last clear reads as an empty list.
	assign head_eff  = head_vld_s1 ? hd_rdata : NULL_LINK;
	assign pool_dest = pool_rdata[VW+EW-1:EW];
	assign pool_next = pool_rdata[EW-1:0];
	assign st_waddr  = VW'(depth_q - DW'(1));
	assign st_raddr  = VW'(depth_q - DW'(2));
	assign push_ok   = !seen_q[pool_dest] && (depth_q != FULL_DEPTH);

	always_comb begin
		case (state_q)
			S_IDLE:  hd_raddr = (req_type == REQ_ADD) ? from_v : src_v;
			default: hd_raddr = pool_dest;
		endcase
	end

	dfs_ram #(.WIDTH(EW), .DEPTH(NUM_VERTICES)) u_head_ram (
		.clk   (clk),
		.we    (state_q == S_ADD),
		.waddr (add_from_q),
		.wdata (used_q),
		.raddr (hd_raddr),
		.rdata (hd_rdata)
	);

	dfs_ram #(.WIDTH(VW + EW), .DEPTH(NUM_EDGES)) u_pool_ram (
		.clk   (clk),
		.we    (state_q == S_ADD),
		.waddr (used_q[AW-1:0]),
		.wdata ({add_to_q, head_eff}),
		.raddr (cur_q[AW-1:0]),
		.rdata (pool_rdata)
	);

	// Frames below the top keep their edge cursor here; the top frame's cursor lives in cur_q.
	dfs_ram #(.WIDTH(EW), .DEPTH(NUM_VERTICES)) u_stack_ram (
		.clk   (clk),
		.we    ((state_q == S_EDGE) && push_ok),
		.waddr (st_waddr),
		.wdata (pool_next),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk) begin
		head_vld_s1 <= head_vld_q[hd_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			depth_q    <= '0;
			used_q     <= '0;
			seen_q     <= '0;
			head_vld_q <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= ((state_q == S_EDGE) && push_ok) || (state_q == S_DONE);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (req_type)
							REQ_CLEAR: begin
								head_vld_q <= '0;
								used_q     <= '0;
							end
							REQ_ADD: begin
								if (from_ok && to_ok && (used_q != NULL_LINK)) begin
									state_q <= S_ADD;
								end
							end
							REQ_SEARCH: begin
								if (src_ok) begin
									seen_q  <= NUM_VERTICES'(1) << src_v;
									depth_q <= DW'(1);
									state_q <= S_HEAD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD: begin
					head_vld_q[add_from_q] <= 1'b1;
					used_q  <= used_q + EW'(1);
					state_q <= S_IDLE;
				end
				S_HEAD: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (cur_q == NULL_LINK) begin
						depth_q <= depth_q - DW'(1);
						state_q <= (depth_q == DW'(1)) ? S_DONE : S_POP;
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					if (push_ok) begin
						seen_q[pool_dest] <= 1'b1;
						depth_q   <= depth_q + DW'(1);
						state_q   <= S_HEAD;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_POP: begin
					state_q <= S_CHECK;
				end
				S_DONE: begin
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: added edge, top cursor, vertex held back for the last flag, result outputs.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				add_from_q <= from_v;
				add_to_q   <= to_v;
				pend_q     <= src_v;
			end
			S_HEAD: begin
				cur_q <= head_eff;
			end
			S_EDGE: begin
				cur_q <= pool_next;
				if (push_ok) begin
					res_vtx_q  <= pend_q;
					res_last_q <= 1'b0;
					pend_q     <= pool_dest;
				end
			end
			S_POP: begin
				cur_q <= st_rdata;
			end
			S_DONE: begin
				res_vtx_q  <= pend_q;
				res_last_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> bench/graph_depth_first_search_test.sv
// Self-checking testbench for the depth-first search block with a queue-fed driver and a monitor.
module graph_depth_first_search_test
	import dfs_pkg::*;
();

	localparam int NV = 16;
	localparam int NE = 64;
	localparam logic [6:0] NULL_LINK = 7'(NE);
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int TOTAL_ITEMS = 220;

	typedef struct {
		logic [1:0] req;
		logic [3:0] tail_v;
		logic [3:0] head_v;
		logic [3:0] src_v;
		int idle_pct;
		bit drain;
	} graph_req_t;

	typedef struct {
		logic [3:0] vertex;
		logic last;
	} visit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] req_type = REQ_CLEAR;
	logic [FIELD_W-1:0] edge_from = '0;
	logic [FIELD_W-1:0] edge_to = '0;
	logic [FIELD_W-1:0] source_vertex = '0;
	logic busy;
	logic result_valid;
	logic [FIELD_W-1:0] visited_vertex;
	logic last_of_search;

	graph_req_t pending_reqs[$];
	visit_t expected_visits[$];
	graph_req_t current;
	bit presenting = 1'b0;
	int item_idx = 0;
	int mismatches = 0;

	// Shadow copy of the graph store and the search stack.
	logic [6:0] graph_heads[NV];
	logic [3:0] edge_dest[NE];
	logic [6:0] edge_link[NE];
	int edges_used;
	logic [NV-1:0] vertex_seen;
	logic [3:0] frame_vertex[NV];
	logic [6:0] frame_cursor[NV];
	int frame_count;

	graph_depth_first_search #(
		.NUM_VERTICES(NV),
		.NUM_EDGES(NE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.edge_from(edge_from),
		.edge_to(edge_to),
		.source_vertex(source_vertex),
		.result_valid(result_valid),
		.visited_vertex(visited_vertex),
		.last_of_search(last_of_search)
	);

	always #4 clk = ~clk;

	task automatic clear_graph_model();
		for (int v = 0; v < NV; v++) graph_heads[v] = NULL_LINK;
		edges_used = 0;
	endtask

	task automatic walk_from(input logic [3:0] src);
		visit_t found[$];
		visit_t step;
		int top;
		logic [6:0] cur;
		logic [3:0] dst;
		vertex_seen = '0;
		vertex_seen[src] = 1'b1;
		frame_vertex[0] = src;
		frame_cursor[0] = graph_heads[src];
		frame_count = 1;
		step.vertex = src;
		step.last = 1'b0;
		found.push_back(step);
		while (frame_count > 0) begin
			top = frame_count - 1;
			cur = frame_cursor[top];
			if (cur >= NULL_LINK) begin
				frame_count = top;
			end else begin
				dst = edge_dest[cur];
				frame_cursor[top] = edge_link[cur];
				if (!vertex_seen[dst] && frame_count < NV) begin
					vertex_seen[dst] = 1'b1;
					frame_vertex[frame_count] = dst;
					frame_cursor[frame_count] = graph_heads[dst];
					frame_count++;
					step.vertex = dst;
					found.push_back(step);
				end
			end
		end
		found[found.size() - 1].last = 1'b1;
		foreach (found[i]) expected_visits.push_back(found[i]);
	endtask

	task automatic predict_item(input graph_req_t it);
		case (it.req)
			REQ_CLEAR: begin
				clear_graph_model();
			end
			REQ_ADD: begin
				if (edges_used < NE) begin
					edge_dest[edges_used] = it.head_v;
					edge_link[edges_used] = graph_heads[it.tail_v];
					graph_heads[it.tail_v] = 7'(edges_used);
					edges_used++;
				end
			end
			REQ_SEARCH: begin
				walk_from(it.src_v);
			end
			default: begin
			end
		endcase
	endtask

	// The idle rate depends on where the item falls in the run, so each idling phase gets its share.
	task automatic queue_item(input logic [1:0] req, input logic [3:0] tail_v,
			input logic [3:0] head_v, input logic [3:0] src_v);
		graph_req_t it;
		it.req = req;
		it.tail_v = tail_v;
		it.head_v = head_v;
		it.src_v = src_v;
		if (item_idx < 55) it.idle_pct = 0;
		else if (item_idx < 115) it.idle_pct = 69;
		else if (item_idx < 170) it.idle_pct = 0;
		else it.idle_pct = 30;
		it.drain = (item_idx % 50 == 25);
		pending_reqs.push_back(it);
		item_idx++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			presenting = 1'b0;
		end else begin
			if (presenting && !busy) begin
				predict_item(current);
				presenting = 1'b0;
			end
			if (!presenting && pending_reqs.size() > 0) begin
				if ((!pending_reqs[0].drain || expected_visits.size() == 0) &&
						$urandom_range(99) >= pending_reqs[0].idle_pct) begin
					current = pending_reqs.pop_front();
					presenting = 1'b1;
					req_type <= current.req;
					edge_from <= current.tail_v;
					edge_to <= current.head_v;
					source_vertex <= current.src_v;
				end
			end
			start <= presenting;
		end
	end

	always @(posedge clk) begin
		visit_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (expected_visits.size() == 0) begin
				$display("%0t unexpected result: expected none, got vertex %0d last %0b",
					$time, visited_vertex, last_of_search);
				mismatches++;
			end else begin
				want = expected_visits.pop_front();
				if (visited_vertex !== want.vertex) begin
					$display("%0t visited_vertex: expected %0d, got %0d",
						$time, want.vertex, visited_vertex);
					mismatches++;
				end
				if (last_of_search !== want.last) begin
					$display("%0t last_of_search: expected %0b, got %0b",
						$time, want.last, last_of_search);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("graph_depth_first_search_test: errors");
		$finish;
	end

	initial begin
		int span;
		int nadd;
		clear_graph_model();

		// Directed part: empty graph, field extremes, self loop, duplicate edge, unused code.
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd0);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd15);
		queue_item(REQ_UNUSED, 4'd15, 4'd15, 4'd15);
		queue_item(REQ_ADD, 4'd0, 4'd15, 4'd0);
		queue_item(REQ_ADD, 4'd15, 4'd0, 4'd15);
		queue_item(REQ_ADD, 4'd5, 4'd5, 4'd0);
		queue_item(REQ_ADD, 4'd0, 4'd5, 4'd0);
		queue_item(REQ_ADD, 4'd0, 4'd15, 4'd0);
		queue_item(REQ_ADD, 4'd15, 4'd10, 4'd0);
		queue_item(REQ_ADD, 4'd10, 4'd5, 4'd0);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd0);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd15);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd5);
		queue_item(REQ_UNUSED, 4'd0, 4'd0, 4'd0);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd10);
		queue_item(REQ_CLEAR, 4'd15, 4'd15, 4'd15);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd0);
		queue_item(REQ_ADD, 4'd3, 4'd12, 4'd0);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd3);
		queue_item(REQ_CLEAR, 4'd0, 4'd0, 4'd0);

		// A chain through every vertex plus enough extra edges to overflow the pool.
		for (int v = 0; v < NV - 1; v++) queue_item(REQ_ADD, 4'(v), 4'(v + 1), 4'd0);
		for (int k = 0; k < NE - (NV - 1) + 4; k++)
			queue_item(REQ_ADD, 4'($urandom_range(15)), 4'($urandom_range(15)), 4'd0);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'd0);
		queue_item(REQ_SEARCH, 4'd0, 4'd0, 4'($urandom_range(15)));

		while (item_idx < TOTAL_ITEMS) begin
			if ($urandom_range(99) < 75) begin
				// Well-formed sequence: optional clear, a batch of edges, then searches.
				span = ($urandom_range(1) == 1) ? 15 : $urandom_range(1, 15);
				nadd = $urandom_range(1, 20);
				if ($urandom_range(99) < 70) queue_item(REQ_CLEAR, 4'd0, 4'd0, 4'd0);
				repeat (nadd)
					queue_item(REQ_ADD, 4'($urandom_range(span)), 4'($urandom_range(span)),
						4'($urandom_range(15)));
				repeat ($urandom_range(1, 3))
					queue_item(REQ_SEARCH, 4'($urandom_range(15)), 4'($urandom_range(15)),
						4'($urandom_range(span)));
			end else begin
				repeat ($urandom_range(1, 4))
					queue_item(2'($urandom_range(3)), 4'($urandom_range(15)),
						4'($urandom_range(15)), 4'($urandom_range(15)));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || presenting) @(posedge clk);
		while (expected_visits.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		if (mismatches == 0) begin
			$display("graph_depth_first_search_test: clean");
		end else begin
			$display("graph_depth_first_search_test: errors");
		end
		$finish;
	end

endmodule
